/* src/tlvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tlvc_pkg;

  // Field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 10;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned BAND_W   = 8;
  localparam int unsigned GOAL_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [VALUE_W-1:0] ANGLE_MAX = 10'd1023;

  // Input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_OPENED = 3'd1,
    OP_CLOSED = 3'd2,
    OP_LEVEL  = 3'd3,
    OP_LIMIT  = 3'd4
  } op_t;

  // Result command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_GET_LEVEL = 2'd0,
    CMD_OPEN      = 2'd1,
    CMD_CLOSE     = 2'd2,
    CMD_SET_LIMIT = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT       = 3'd0,
    CFG_OUTFLOW_BAND   = 3'd1,
    CFG_FULL_OPEN_BAND = 3'd2,
    CFG_INITIAL_ANGLE  = 3'd3,
    CFG_INITIAL_LEVEL  = 3'd4,
    CFG_INITIAL_LIMIT  = 3'd5
  } cfg_idx_t;

  // Position of the next result within a tick
  typedef enum logic [1:0] {
    PHASE_GET   = 2'd0,
    PHASE_VALVE = 2'd1,
    PHASE_SET   = 2'd2
  } phase_t;

  // Register reset values
  localparam logic [VALUE_W-1:0] SETPOINT_RST       = 10'd80;
  localparam logic [BAND_W-1:0]  OUTFLOW_BAND_RST   = 8'd2;
  localparam logic [BAND_W-1:0]  FULL_OPEN_BAND_RST = 8'd5;
  localparam logic [VALUE_W-1:0] INITIAL_ANGLE_RST  = 10'd0;
  localparam logic [VALUE_W-1:0] INITIAL_LEVEL_RST  = 10'd0;
  localparam logic [VALUE_W-1:0] INITIAL_LIMIT_RST  = 10'd0;

  // Targets
  localparam logic [VALUE_W-1:0] LIMIT_LOW  = 10'd0;
  localparam logic [VALUE_W-1:0] LIMIT_MID  = 10'd80;
  localparam logic [VALUE_W-1:0] LIMIT_HIGH = 10'd100;
  localparam logic [GOAL_W-1:0]  GOAL_FULL  = 7'd100;
  localparam logic [GOAL_W-1:0]  GOAL_HALF  = 7'd50;
  localparam logic [GOAL_W-1:0]  GOAL_SHUT  = 7'd0;

endpackage

`default_nettype wire

/* src/tank_level_onoff_valve_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

// Tank level controller: plant reports (opened, closed, level, limit) update
// the valve angle bounds and the stored level and limit in the cycle they
// transfer and give no result. A tick computes the outflow limit target and
// the valve angle goal in the cycle it transfers and loads a tick record;
// the record then drives out a get-level command, an optional open or close
// command and a set-limit command (last high), one per cycle while the
// result side does not stall. A tick thus gives two or three results; the
// next tick can transfer in the cycle of the previous tick's final result
// transfer, and reports may transfer at any cycle the record is free or
// finishing. Configuration writes take effect at once; the preset registers
// also load the matching state.
module tank_level_onoff_valve_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [tlvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tlvc_pkg::VALUE_W-1:0]  cfg_data,
  // input items
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [tlvc_pkg::OP_W-1:0]     op,
  input  wire logic [tlvc_pkg::VALUE_W-1:0]  value,
  // result items
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [tlvc_pkg::CMD_W-1:0]         command,
  output logic [tlvc_pkg::VALUE_W-1:0]       command_value,
  output logic [tlvc_pkg::VALUE_W-1:0]       angle_estimate,
  output logic [tlvc_pkg::VALUE_W-1:0]       shown_level,
  output logic [tlvc_pkg::VALUE_W-1:0]       shown_limit,
  output logic                               last
);

  localparam int unsigned VW = tlvc_pkg::VALUE_W;
  localparam int unsigned BW = tlvc_pkg::BAND_W;
  localparam int unsigned GW = tlvc_pkg::GOAL_W;
  localparam int unsigned EW = VW + 2;  // signed error width

  // Configuration registers
  logic [VW-1:0] setpoint;
  logic [BW-1:0] outflow_band;
  logic [BW-1:0] full_open_band;

  // Controller state
  logic [VW-1:0] angle_low;
  logic [VW-1:0] angle_high;
  logic [VW-1:0] level_seen;
  logic [VW-1:0] limit_seen;
  logic [GW-1:0] angle_goal;

  // Tick record
  logic                 busy;
  tlvc_pkg::phase_t     phase;
  logic                 rec_has_valve;
  tlvc_pkg::cmd_t       rec_valve_cmd;
  logic [VW-1:0]        rec_amount;
  logic [VW-1:0]        rec_limit_target;
  logic [VW-1:0]        rec_estimate;
  logic [VW-1:0]        rec_level;
  logic [VW-1:0]        rec_limit;

  logic item_xfer;
  logic result_xfer;
  logic final_xfer;
  logic tick_xfer;

  // Tick computation
  logic signed [EW-1:0] err;
  logic signed [EW-1:0] band_s;
  logic signed [EW-1:0] fob_s;
  logic [VW-1:0]        limit_target;
  logic [GW-1:0]        goal_next;
  logic [VW-1:0]        goal_wide;
  logic                 open_need;
  logic                 close_need;
  logic [VW-1:0]        angle_low_tick;
  logic [VW-1:0]        angle_high_tick;
  logic [VW:0]          angle_sum;
  logic [VW:0]          opened_sum;

  // Handshake
  assign result_xfer = result_valid && !result_stall;
  assign final_xfer  = result_xfer && (phase == tlvc_pkg::PHASE_SET);
  assign item_stall  = busy && !final_xfer;
  assign item_xfer   = item_valid && !item_stall;
  assign tick_xfer   = item_xfer && (tlvc_pkg::op_t'(op) == tlvc_pkg::OP_TICK);

  // Error and targets
  always_comb begin
    err    = $signed({2'b00, setpoint}) - $signed({2'b00, level_seen});
    band_s = $signed({{(EW-BW){1'b0}}, outflow_band});
    fob_s  = $signed({{(EW-BW){1'b0}}, full_open_band});

    if (err > band_s) begin
      limit_target = tlvc_pkg::LIMIT_LOW;
    end else if (err < -band_s) begin
      limit_target = tlvc_pkg::LIMIT_HIGH;
    end else begin
      limit_target = tlvc_pkg::LIMIT_MID;
    end

    if (err > fob_s) begin
      goal_next = tlvc_pkg::GOAL_FULL;
    end else if (err > 0) begin
      goal_next = tlvc_pkg::GOAL_HALF;
    end else if (err < 0) begin
      goal_next = tlvc_pkg::GOAL_SHUT;
    end else begin
      goal_next = angle_goal;
    end

    goal_wide  = {{(VW-GW){1'b0}}, goal_next};
    open_need  = goal_wide > angle_high;
    close_need = !open_need && (goal_wide < angle_low);

    angle_low_tick  = close_need ? goal_wide : angle_low;
    angle_high_tick = open_need ? goal_wide : angle_high;
    angle_sum       = {1'b0, angle_low_tick} + {1'b0, angle_high_tick};
    opened_sum      = {1'b0, angle_low} + {1'b0, value};
  end

  // Configuration and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= tlvc_pkg::SETPOINT_RST;
      outflow_band   <= tlvc_pkg::OUTFLOW_BAND_RST;
      full_open_band <= tlvc_pkg::FULL_OPEN_BAND_RST;
      angle_low      <= tlvc_pkg::INITIAL_ANGLE_RST;
      angle_high     <= tlvc_pkg::INITIAL_ANGLE_RST;
      level_seen     <= tlvc_pkg::INITIAL_LEVEL_RST;
      limit_seen     <= tlvc_pkg::INITIAL_LIMIT_RST;
      angle_goal     <= '0;
    end else begin
      // apply plant reports and ticks
      if (item_xfer) begin
        case (tlvc_pkg::op_t'(op))
          tlvc_pkg::OP_TICK: begin
            angle_goal <= goal_next;
            angle_low  <= angle_low_tick;
            angle_high <= angle_high_tick;
          end
          tlvc_pkg::OP_OPENED: begin
            angle_low <= opened_sum[VW] ? tlvc_pkg::ANGLE_MAX : opened_sum[VW-1:0];
          end
          tlvc_pkg::OP_CLOSED: begin
            angle_high <= (value > angle_high) ? '0 : angle_high - value;
          end
          tlvc_pkg::OP_LEVEL: level_seen <= value;
          tlvc_pkg::OP_LIMIT: limit_seen <= value;
          default: ;
        endcase
      end
      // configuration writes; presets load the matching state
      if (cfg_write) begin
        unique case (tlvc_pkg::cfg_idx_t'(cfg_index))
          tlvc_pkg::CFG_SETPOINT:       setpoint       <= cfg_data;
          tlvc_pkg::CFG_OUTFLOW_BAND:   outflow_band   <= cfg_data[BW-1:0];
          tlvc_pkg::CFG_FULL_OPEN_BAND: full_open_band <= cfg_data[BW-1:0];
          tlvc_pkg::CFG_INITIAL_ANGLE: begin
            angle_low  <= cfg_data;
            angle_high <= cfg_data;
          end
          tlvc_pkg::CFG_INITIAL_LEVEL: level_seen <= cfg_data;
          tlvc_pkg::CFG_INITIAL_LIMIT: limit_seen <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Tick record control: load on a tick, advance on each result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= tlvc_pkg::PHASE_GET;
    end else if (tick_xfer) begin
      busy  <= 1'b1;
      phase <= tlvc_pkg::PHASE_GET;
    end else if (result_xfer) begin
      unique case (phase)
        tlvc_pkg::PHASE_GET:
          phase <= rec_has_valve ? tlvc_pkg::PHASE_VALVE : tlvc_pkg::PHASE_SET;
        tlvc_pkg::PHASE_VALVE: phase <= tlvc_pkg::PHASE_SET;
        tlvc_pkg::PHASE_SET:   busy  <= 1'b0;
        default:               busy  <= 1'b0;
      endcase
    end
  end

  // Tick record payload
  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      rec_has_valve    <= open_need || close_need;
      rec_valve_cmd    <= open_need ? tlvc_pkg::CMD_OPEN : tlvc_pkg::CMD_CLOSE;
      rec_amount       <= open_need ? goal_wide - angle_high : angle_low - goal_wide;
      rec_limit_target <= limit_target;
      rec_estimate     <= angle_sum[VW:1];
      rec_level        <= level_seen;
      rec_limit        <= limit_seen;
    end
  end

  // Result selection
  always_comb begin
    result_valid   = busy;
    angle_estimate = rec_estimate;
    shown_level    = rec_level;
    shown_limit    = rec_limit;
    unique case (phase)
      tlvc_pkg::PHASE_GET: begin
        command       = tlvc_pkg::CMD_GET_LEVEL;
        command_value = '0;
        last          = 1'b0;
      end
      tlvc_pkg::PHASE_VALVE: begin
        command       = rec_valve_cmd;
        command_value = rec_amount;
        last          = 1'b0;
      end
      default: begin
        command       = tlvc_pkg::CMD_SET_LIMIT;
        command_value = rec_limit_target;
        last          = 1'b1;
      end
    endcase
  end

  // Checks
  a_last_is_set: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> command == tlvc_pkg::CMD_SET_LIMIT)
    else $error("last flag on a command other than set limit");

  a_valve_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (command == tlvc_pkg::CMD_OPEN || command == tlvc_pkg::CMD_CLOSE)
    |-> command_value != '0)
    else $error("valve command with zero amount");

  a_tick_starts_get: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> command == tlvc_pkg::CMD_GET_LEVEL)
    else $error("tick does not start with get level");

  a_final_drains: assert property (@(posedge clk) disable iff (rst)
    final_xfer && !tick_xfer |=> !result_valid)
    else $error("results continue after final transfer");

endmodule

`default_nettype wire
